// ===== rtl/attw_pkg.sv =====
// Shared types, widths and constants for the atlas triangle texel writer.
`timescale 1ns / 1ps

package attw_pkg;

	localparam int MAX_TEX_DIM      = 1024;
	localparam int MAX_TRIANGLES    = 4096;
	localparam int WEIGHT_FRAC_BITS = 15;

	localparam int TRI_IDX_W = 12;
	localparam int WEIGHT_W  = 16;
	localparam int COLOR_W   = 8;
	localparam int TEXEL_W   = 10;
	localparam int ADDR_W    = 22;

	localparam int DIM_W   = 11;
	localparam int COUNT_W = 13;
	localparam int SPR_W   = 7;
	localparam int CELL_W  = 11;

	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 13;

	localparam logic [CFG_INDEX_W-1:0] REG_TEXTURE_WIDTH   = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_TEXTURE_HEIGHT  = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_TRIANGLE_COUNT  = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_SQUARES_PER_ROW = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_CELL_WIDTH      = 3'd4;
	localparam logic [CFG_INDEX_W-1:0] REG_CELL_HEIGHT     = 3'd5;

	// square divider: 11-bit square number padded to 12, four quotient bits per stage
	localparam int SQ_W       = TRI_IDX_W - 1;
	localparam int DIV_STEPS  = 4;
	localparam int DIV_STAGES = 3;
	localparam int QUO_W      = DIV_STEPS * DIV_STAGES;
	localparam int REM_W      = SPR_W;

	// datapath widths
	localparam int BX_W  = REM_W + CELL_W;
	localparam int BY_W  = SQ_W + CELL_W;
	localparam int PX_W  = BX_W + 2;
	localparam int PY_W  = BY_W + 2;
	localparam int CX_W  = PX_W + 1;
	localparam int CY_W  = PY_W + 1;
	localparam int WS_W  = WEIGHT_W + 1;
	localparam int PRX_W = CX_W + WS_W;
	localparam int PRY_W = CY_W + WS_W;
	localparam int SX_W  = PRX_W + 2;
	localparam int SY_W  = PRY_W + 2;
	localparam int SHIFT = WEIGHT_FRAC_BITS + 1;
	localparam int XR_W  = SX_W - SHIFT;
	localparam int YR_W  = SY_W - SHIFT;
	localparam int LIN_W = TEXEL_W + DIM_W;

	localparam logic [SHIFT-1:0] TRUNC_MASK = '1;

	typedef struct packed {
		logic [TRI_IDX_W-1:0] triangle_index;
		logic [WEIGHT_W-1:0]  weight_a;
		logic [WEIGHT_W-1:0]  weight_b;
		logic [WEIGHT_W-1:0]  weight_c;
		logic [COLOR_W-1:0]   red;
		logic [COLOR_W-1:0]   green;
		logic [COLOR_W-1:0]   blue;
	} sample_t;

	typedef struct packed {
		logic                 write_valid;
		logic [TEXEL_W-1:0]   texel_x;
		logic [TEXEL_W-1:0]   texel_y;
		logic [ADDR_W-1:0]    byte_address;
		logic [COLOR_W-1:0]   out_red;
		logic [COLOR_W-1:0]   out_green;
		logic [COLOR_W-1:0]   out_blue;
	} texel_t;

	typedef struct packed {
		logic [COLOR_W-1:0] red;
		logic [COLOR_W-1:0] green;
		logic [COLOR_W-1:0] blue;
	} rgb_t;

	// effective configuration, already saturated
	typedef struct packed {
		logic [DIM_W-1:0]   tex_w;
		logic [DIM_W-1:0]   tex_h;
		logic [COUNT_W-1:0] tri_count;
		logic [SPR_W-1:0]   sq_per_row;
		logic [CELL_W-1:0]  cell_w;
		logic [CELL_W-1:0]  cell_h;
	} cfg_t;

	typedef struct packed {
		logic [REM_W-1:0] rem;
		logic [QUO_W-1:0] quo;
	} div_t;

endpackage

// ===== rtl/attw_cfg_regs.sv =====
// Configuration register file with saturation of the programmed values.
`timescale 1ns / 1ps

module attw_cfg_regs (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [attw_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [attw_pkg::CFG_DATA_W-1:0]  cfg_data,
	output attw_pkg::cfg_t                  cfg
);
	import attw_pkg::*;

	logic [DIM_W-1:0]   tex_w_q;
	logic [DIM_W-1:0]   tex_h_q;
	logic [COUNT_W-1:0] tri_count_q;
	logic [SPR_W-1:0]   sq_per_row_q;
	logic [CELL_W-1:0]  cell_w_q;
	logic [CELL_W-1:0]  cell_h_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tex_w_q      <= DIM_W'(1024);
			tex_h_q      <= DIM_W'(1024);
			tri_count_q  <= COUNT_W'(12);
			sq_per_row_q <= SPR_W'(3);
			cell_w_q     <= CELL_W'(341);
			cell_h_q     <= CELL_W'(341);
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_TEXTURE_WIDTH:   tex_w_q      <= cfg_data[DIM_W-1:0];
				REG_TEXTURE_HEIGHT:  tex_h_q      <= cfg_data[DIM_W-1:0];
				REG_TRIANGLE_COUNT:  tri_count_q  <= cfg_data[COUNT_W-1:0];
				REG_SQUARES_PER_ROW: sq_per_row_q <= cfg_data[SPR_W-1:0];
				REG_CELL_WIDTH:      cell_w_q     <= cfg_data[CELL_W-1:0];
				REG_CELL_HEIGHT:     cell_h_q     <= cfg_data[CELL_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		cfg.tex_w      = (tex_w_q > DIM_W'(MAX_TEX_DIM)) ? DIM_W'(MAX_TEX_DIM) : tex_w_q;
		cfg.tex_h      = (tex_h_q > DIM_W'(MAX_TEX_DIM)) ? DIM_W'(MAX_TEX_DIM) : tex_h_q;
		cfg.tri_count  = (tri_count_q > COUNT_W'(MAX_TRIANGLES)) ?
			COUNT_W'(MAX_TRIANGLES) : tri_count_q;
		cfg.sq_per_row = (sq_per_row_q == '0) ? SPR_W'(1) : sq_per_row_q;
		cfg.cell_w     = cell_w_q;
		cfg.cell_h     = cell_h_q;
	end

endmodule

// ===== rtl/attw_div_step.sv =====
// Four restoring division steps of the square number by squares per row.
`timescale 1ns / 1ps

module attw_div_step (
	input  logic [attw_pkg::SPR_W-1:0]     divisor,
	input  logic [attw_pkg::DIV_STEPS-1:0] bits,
	input  attw_pkg::div_t                 prev,
	output attw_pkg::div_t                 next
);
	import attw_pkg::*;

	logic [REM_W:0]   trial;
	logic [REM_W-1:0] rem;
	logic [QUO_W-1:0] quo;

	always_comb begin
		rem = prev.rem;
		quo = prev.quo;
		trial = '0;
		for (int i = 0; i < DIV_STEPS; i++) begin
			trial = {rem, bits[DIV_STEPS-1-i]};
			if (trial >= {1'b0, divisor}) begin
				trial = trial - {1'b0, divisor};
				quo = {quo[QUO_W-2:0], 1'b1};
			end else begin
				quo = {quo[QUO_W-2:0], 1'b0};
			end
			rem = trial[REM_W-1:0];
		end
		next.rem = rem;
		next.quo = quo;
	end

endmodule

// ===== rtl/atlas_triangle_texel_writer_unit.sv =====
// Top level of the atlas triangle texel writer: ten-stage texel write pipeline.
`timescale 1ns / 1ps

// Takes one sample transaction per cycle while sample_stall is low and returns exactly one texel
// transaction per sample, in order. Stages 1-3 divide
// the square number by squares per row, stage 4 places the square, stage 5 forms the vertex
// centres, stage 6 weights them, stage 7 sums, stage 8 truncates and bounds-checks, stages
// 9-10 form the byte address. Each stage holds its transaction under stall and empty stages
// fill up, so input is taken while a finished result waits. A suppressed write comes out with
// write_valid low and all other fields zero. Configuration writes are always ready and must
// only be issued while the pipeline is empty; there is no clearing pass after reset.
module atlas_triangle_texel_writer_unit (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             sample_valid,
	output logic                             sample_stall,
	input  attw_pkg::sample_t                sample,
	output logic                             texel_valid,
	input  logic                             texel_stall,
	output attw_pkg::texel_t                 texel,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [attw_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [attw_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import attw_pkg::*;

	cfg_t cfg;

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9, v_s10;
	logic load1, load2, load3, load4, load5, load6, load7, load8, load9, load10;

	sample_t item_s1, item_s2, item_s3, item_s4, item_s5;
	logic    inr_s1, inr_s2, inr_s3, inr_s4, inr_s5, inr_s6, inr_s7;
	div_t    div_s1, div_s2, div_s3;
	div_t    div_n1, div_n2, div_n3;
	logic [QUO_W-1:0] sq_in, sq_s1, sq_s2;

	logic [BX_W-1:0] bx_s4, bx_n;
	logic [BY_W-1:0] by_s4, by_n;

	logic signed [PX_W-1:0] px_b, px_bc, x0, x1, x2;
	logic signed [PY_W-1:0] py_b, py_bc, y0, y1, y2;
	logic signed [CX_W-1:0] cx0_s5, cx1_s5, cx2_s5;
	logic signed [CY_W-1:0] cy0_s5, cy1_s5, cy2_s5;

	logic signed [PRX_W-1:0] prx0_s6, prx1_s6, prx2_s6;
	logic signed [PRY_W-1:0] pry0_s6, pry1_s6, pry2_s6;
	rgb_t rgb_s6, rgb_s7, rgb_s8, rgb_s9;

	logic signed [SX_W-1:0] sx_s7, sx_adj;
	logic signed [SY_W-1:0] sy_s7, sy_adj;
	logic [XR_W-1:0] xr;
	logic [YR_W-1:0] yr;
	logic            x_ok, y_ok;

	logic [TEXEL_W-1:0] x_s8, y_s8, x_s9, y_s9;
	logic               wr_s8, wr_s9;
	logic [LIN_W-1:0]   yw_s9, lin;
	logic [ADDR_W-1:0]  addr;
	texel_t             out_s10;

	attw_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// stage advance: a stage loads when empty or when the next one loads
	assign load10 = !v_s10 || !texel_stall;
	assign load9  = !v_s9 || load10;
	assign load8  = !v_s8 || load9;
	assign load7  = !v_s7 || load8;
	assign load6  = !v_s6 || load7;
	assign load5  = !v_s5 || load6;
	assign load4  = !v_s4 || load5;
	assign load3  = !v_s3 || load4;
	assign load2  = !v_s2 || load3;
	assign load1  = !v_s1 || load2;

	assign sample_stall = !load1;
	assign texel_valid  = v_s10;
	assign texel        = out_s10;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
			v_s3  <= 1'b0;
			v_s4  <= 1'b0;
			v_s5  <= 1'b0;
			v_s6  <= 1'b0;
			v_s7  <= 1'b0;
			v_s8  <= 1'b0;
			v_s9  <= 1'b0;
			v_s10 <= 1'b0;
		end else begin
			if (load1)  v_s1  <= sample_valid;
			if (load2)  v_s2  <= v_s1;
			if (load3)  v_s3  <= v_s2;
			if (load4)  v_s4  <= v_s3;
			if (load5)  v_s5  <= v_s4;
			if (load6)  v_s6  <= v_s5;
			if (load7)  v_s7  <= v_s6;
			if (load8)  v_s8  <= v_s7;
			if (load9)  v_s9  <= v_s8;
			if (load10) v_s10 <= v_s9;
		end
	end

	// stages 1-3: square number divided by squares per row
	assign sq_in = QUO_W'(sample.triangle_index[TRI_IDX_W-1:1]);

	attw_div_step u_div1 (
		.divisor (cfg.sq_per_row),
		.bits    (sq_in[QUO_W-1 -: DIV_STEPS]),
		.prev    ('0),
		.next    (div_n1)
	);

	attw_div_step u_div2 (
		.divisor (cfg.sq_per_row),
		.bits    (sq_s1[QUO_W-DIV_STEPS-1 -: DIV_STEPS]),
		.prev    (div_s1),
		.next    (div_n2)
	);

	attw_div_step u_div3 (
		.divisor (cfg.sq_per_row),
		.bits    (sq_s2[DIV_STEPS-1:0]),
		.prev    (div_s2),
		.next    (div_n3)
	);

	always_ff @(posedge clk) begin
		if (load1) begin
			item_s1 <= sample;
			sq_s1   <= sq_in;
			div_s1  <= div_n1;
			inr_s1  <= {1'b0, sample.triangle_index} < cfg.tri_count;
		end
		if (load2) begin
			item_s2 <= item_s1;
			sq_s2   <= sq_s1;
			div_s2  <= div_n2;
			inr_s2  <= inr_s1;
		end
		if (load3) begin
			item_s3 <= item_s2;
			div_s3  <= div_n3;
			inr_s3  <= inr_s2;
		end
	end

	// stage 4: square origin in texels
	assign bx_n = BX_W'(div_s3.rem) * BX_W'(cfg.cell_w);
	assign by_n = BY_W'(div_s3.quo[SQ_W-1:0]) * BY_W'(cfg.cell_h);

	always_ff @(posedge clk) begin
		if (load4) begin
			item_s4 <= item_s3;
			inr_s4  <= inr_s3;
			bx_s4   <= bx_n;
			by_s4   <= by_n;
		end
	end

	// stage 5: vertex centres as 2p+1
	always_comb begin
		px_b  = $signed(PX_W'(bx_s4));
		px_bc = px_b + $signed(PX_W'(cfg.cell_w));
		py_b  = $signed(PY_W'(by_s4));
		py_bc = py_b + $signed(PY_W'(cfg.cell_h));
		y0    = py_b + PY_W'(1);
		y1    = py_bc - PY_W'(2);
		if (item_s4.triangle_index[0]) begin
			x0 = px_b + PX_W'(3);
			x1 = px_bc - PX_W'(1);
			x2 = px_bc - PX_W'(2);
			y2 = py_b + PY_W'(1);
		end else begin
			x0 = px_b + PX_W'(1);
			x1 = px_bc - PX_W'(2);
			x2 = px_b + PX_W'(1);
			y2 = py_bc - PY_W'(2);
		end
	end

	always_ff @(posedge clk) begin
		if (load5) begin
			item_s5 <= item_s4;
			inr_s5  <= inr_s4;
			cx0_s5  <= {x0, 1'b1};
			cx1_s5  <= {x1, 1'b1};
			cx2_s5  <= {x2, 1'b1};
			cy0_s5  <= {y0, 1'b1};
			cy1_s5  <= {y1, 1'b1};
			cy2_s5  <= {y2, 1'b1};
		end
	end

	// stage 6: weighted centres
	always_ff @(posedge clk) begin
		if (load6) begin
			inr_s6  <= inr_s5;
			rgb_s6  <= '{red: item_s5.red, green: item_s5.green, blue: item_s5.blue};
			prx0_s6 <= PRX_W'(cx0_s5) * $signed(PRX_W'({1'b0, item_s5.weight_a}));
			prx1_s6 <= PRX_W'(cx1_s5) * $signed(PRX_W'({1'b0, item_s5.weight_b}));
			prx2_s6 <= PRX_W'(cx2_s5) * $signed(PRX_W'({1'b0, item_s5.weight_c}));
			pry0_s6 <= PRY_W'(cy0_s5) * $signed(PRY_W'({1'b0, item_s5.weight_a}));
			pry1_s6 <= PRY_W'(cy1_s5) * $signed(PRY_W'({1'b0, item_s5.weight_b}));
			pry2_s6 <= PRY_W'(cy2_s5) * $signed(PRY_W'({1'b0, item_s5.weight_c}));
		end
	end

	// stage 7: sums
	always_ff @(posedge clk) begin
		if (load7) begin
			inr_s7 <= inr_s6;
			rgb_s7 <= rgb_s6;
			sx_s7  <= SX_W'(prx0_s6) + SX_W'(prx1_s6) + SX_W'(prx2_s6);
			sy_s7  <= SY_W'(pry0_s6) + SY_W'(pry1_s6) + SY_W'(pry2_s6);
		end
	end

	// stage 8: truncate toward zero, bounds check
	always_comb begin
		sx_adj = sx_s7 + (sx_s7[SX_W-1] ? $signed(SX_W'(TRUNC_MASK)) : $signed(SX_W'(0)));
		sy_adj = sy_s7 + (sy_s7[SY_W-1] ? $signed(SY_W'(TRUNC_MASK)) : $signed(SY_W'(0)));
		xr     = sx_adj[SX_W-1:SHIFT];
		yr     = sy_adj[SY_W-1:SHIFT];
		x_ok   = !xr[XR_W-1] && (xr < XR_W'(cfg.tex_w));
		y_ok   = !yr[YR_W-1] && (yr < YR_W'(cfg.tex_h));
	end

	always_ff @(posedge clk) begin
		if (load8) begin
			rgb_s8 <= rgb_s7;
			wr_s8  <= inr_s7 && x_ok && y_ok;
			x_s8   <= xr[TEXEL_W-1:0];
			y_s8   <= yr[TEXEL_W-1:0];
		end
	end

	// stage 9: row offset
	always_ff @(posedge clk) begin
		if (load9) begin
			rgb_s9 <= rgb_s8;
			wr_s9  <= wr_s8;
			x_s9   <= x_s8;
			y_s9   <= y_s8;
			yw_s9  <= LIN_W'(y_s8) * LIN_W'(cfg.tex_w);
		end
	end

	// stage 10: byte address and output register
	assign lin  = yw_s9 + LIN_W'(x_s9);
	assign addr = ADDR_W'({lin, 1'b0}) + ADDR_W'(lin);

	always_ff @(posedge clk) begin
		if (load10) begin
			if (wr_s9) begin
				out_s10.write_valid  <= 1'b1;
				out_s10.texel_x      <= x_s9;
				out_s10.texel_y      <= y_s9;
				out_s10.byte_address <= addr;
				out_s10.out_red      <= rgb_s9.red;
				out_s10.out_green    <= rgb_s9.green;
				out_s10.out_blue     <= rgb_s9.blue;
			end else begin
				out_s10 <= '0;
			end
		end
	end

endmodule

// ===== rtl/attw_checker.sv =====
// Port-level assertions for the atlas triangle texel writer, bound to the top level.
`timescale 1ns / 1ps

module attw_checker (
	input logic             clk,
	input logic             arst_n,
	input logic             sample_valid,
	input logic             sample_stall,
	input logic             texel_valid,
	input logic             texel_stall,
	input attw_pkg::texel_t texel
);
	import attw_pkg::*;

	// held result transaction stays put
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		texel_valid && texel_stall |=> texel_valid && $stable(texel))
		else $error("texel transaction changed while stalled");

	// offered sample transaction is not withdrawn while stalled
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		sample_valid && sample_stall |=> sample_valid)
		else $error("sample transaction withdrawn while stalled");

	// suppressed write carries all-zero fields
	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		texel_valid && !texel.write_valid |->
			texel.texel_x == '0 && texel.texel_y == '0 && texel.byte_address == '0 &&
			texel.out_red == '0 && texel.out_green == '0 && texel.out_blue == '0)
		else $error("suppressed write with nonzero fields");

	// input backpressure only when the pipe is full behind a stalled result
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		sample_stall |-> texel_valid && texel_stall)
		else $error("sample stalled without output backpressure");

	// address is at least three times the column
	a_addr: assert property (@(posedge clk) disable iff (!arst_n)
		texel_valid && texel.write_valid |->
			texel.byte_address >= ADDR_W'({texel.texel_x, 1'b0}) + ADDR_W'(texel.texel_x))
		else $error("byte address below column offset");

endmodule

bind atlas_triangle_texel_writer_unit attw_checker u_attw_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.sample_valid (sample_valid),
	.sample_stall (sample_stall),
	.texel_valid  (texel_valid),
	.texel_stall  (texel_stall),
	.texel        (texel)
);

// ===== tb/testbench.sv =====
// Self-checking testbench for the atlas triangle texel writer: random and directed samples.
`timescale 1ns / 1ps

module testbench;
	import attw_pkg::*;

	localparam int HOLD_CYCLES  = 400;
	localparam int STALL_LIMIT  = 2000;
	localparam int DRAIN_CYCLES = 16;
	localparam int PHASES       = 12;
	localparam int ITEMS_PER_PH = 150;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   sample_valid = 1'b0;
	logic                   sample_stall;
	sample_t                sample = '0;
	logic                   texel_valid;
	logic                   texel_stall = 1'b0;
	texel_t                 texel;
	logic                   cfg_valid = 1'b0;
	logic                   cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0]  cfg_data = '0;

	// shadow copy of the configuration registers
	logic [DIM_W-1:0]   reg_tex_w = 11'd1024;
	logic [DIM_W-1:0]   reg_tex_h = 11'd1024;
	logic [COUNT_W-1:0] reg_tri_count = 13'd12;
	logic [SPR_W-1:0]   reg_sq_per_row = 7'd3;
	logic [CELL_W-1:0]  reg_cell_w = 11'd341;
	logic [CELL_W-1:0]  reg_cell_h = 11'd341;

	sample_t sample_backlog[$];
	texel_t  expected_writes[$];
	int      fail_count = 0;
	int      send_gap_pct = 0;
	int      recv_hold_pct = 0;
	logic    hold_armed = 1'b0;
	int      hold_count = 0;
	int      quiet_cycles = 0;
	logic [CFG_DATA_W-1:0] cfg_plan [PHASES][6];

	atlas_triangle_texel_writer_unit dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.sample       (sample),
		.texel_valid  (texel_valid),
		.texel_stall  (texel_stall),
		.texel        (texel),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// weighted sum of vertex centres (2p+1), truncated toward zero
	function automatic longint centre_blend(longint p0, longint p1, longint p2,
		longint w0, longint w1, longint w2);
		longint acc;
		acc = (2 * p0 + 1) * w0 + (2 * p1 + 1) * w1 + (2 * p2 + 1) * w2;
		if (acc >= 0)
			return acc >>> (WEIGHT_FRAC_BITS + 1);
		return -((-acc) >>> (WEIGHT_FRAC_BITS + 1));
	endfunction

	function automatic texel_t predict_write(sample_t s);
		texel_t r;
		longint tw, th, tc, spr, cw, ch, sq, bx, by;
		longint x0, x1, x2, y0, y1, y2, x, y, wa, wb, wc, lin;
		r = '0;
		tw = (reg_tex_w > MAX_TEX_DIM) ? MAX_TEX_DIM : reg_tex_w;
		th = (reg_tex_h > MAX_TEX_DIM) ? MAX_TEX_DIM : reg_tex_h;
		tc = (reg_tri_count > MAX_TRIANGLES) ? MAX_TRIANGLES : reg_tri_count;
		spr = (reg_sq_per_row == 0) ? 1 : reg_sq_per_row;
		cw = reg_cell_w;
		ch = reg_cell_h;
		wa = s.weight_a;
		wb = s.weight_b;
		wc = s.weight_c;
		if (longint'(s.triangle_index) >= tc)
			return r;
		sq = s.triangle_index >> 1;
		bx = (sq % spr) * cw;
		by = (sq / spr) * ch;
		if (!s.triangle_index[0]) begin
			x0 = bx + 1; x1 = bx + cw - 2; x2 = bx + 1;
			y0 = by + 1; y1 = by + ch - 2; y2 = by + ch - 2;
		end else begin
			x0 = bx + 3; x1 = bx + cw - 1; x2 = bx + cw - 2;
			y0 = by + 1; y1 = by + ch - 2; y2 = by + 1;
		end
		x = centre_blend(x0, x1, x2, wa, wb, wc);
		y = centre_blend(y0, y1, y2, wa, wb, wc);
		if (x < 0 || y < 0 || x >= tw || y >= th)
			return r;
		lin = (y * tw + x) * 3;
		r.write_valid = 1'b1;
		r.texel_x = x[TEXEL_W-1:0];
		r.texel_y = y[TEXEL_W-1:0];
		r.byte_address = lin[ADDR_W-1:0];
		r.out_red = s.red;
		r.out_green = s.green;
		r.out_blue = s.blue;
		return r;
	endfunction

	task automatic flag_failure(string msg);
		fail_count++;
		if (fail_count <= 10)
			$display("%0t: %s", $realtime, msg);
	endtask

	task automatic check_field(string field, longint want, longint got);
		if (want != got)
			flag_failure($sformatf("texel field %s: expected %0d, got %0d", field, want, got));
	endtask

	// sender
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_valid <= 1'b0;
			sample <= '0;
		end else begin
			if (sample_valid && !sample_stall)
				expected_writes.push_back(predict_write(sample));
			if (!sample_valid || !sample_stall) begin
				if (sample_backlog.size() > 0 && $urandom_range(99) >= send_gap_pct) begin
					sample <= sample_backlog.pop_front();
					sample_valid <= 1'b1;
				end else begin
					sample_valid <= 1'b0;
				end
			end
		end
	end

	// receiver and checker
	always @(posedge clk or negedge arst_n) begin : texel_monitor
		texel_t want;
		if (!arst_n) begin
			texel_stall <= 1'b0;
			hold_count <= 0;
		end else begin
			if (texel_valid && !texel_stall) begin
				if (expected_writes.size() == 0) begin
					flag_failure("texel transaction with nothing expected");
				end else begin
					want = expected_writes.pop_front();
					check_field("write_valid", want.write_valid, texel.write_valid);
					check_field("texel_x", want.texel_x, texel.texel_x);
					check_field("texel_y", want.texel_y, texel.texel_y);
					check_field("byte_address", want.byte_address, texel.byte_address);
					check_field("out_red", want.out_red, texel.out_red);
					check_field("out_green", want.out_green, texel.out_green);
					check_field("out_blue", want.out_blue, texel.out_blue);
				end
			end
			if (hold_armed && hold_count < HOLD_CYCLES) begin
				texel_stall <= 1'b1;
				hold_count <= hold_count + 1;
			end else begin
				texel_stall <= ($urandom_range(99) < recv_hold_pct);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((sample_valid && !sample_stall) || (texel_valid && !texel_stall) ||
				(cfg_valid && cfg_ready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("[atlas_triangle_texel_writer_unit] ERROR");
				$finish;
			end
		end
	end

	task automatic add_sample(int idx, int wa, int wb, int wc, int r, int g, int b);
		sample_t s;
		s.triangle_index = TRI_IDX_W'(idx);
		s.weight_a = WEIGHT_W'(wa);
		s.weight_b = WEIGHT_W'(wb);
		s.weight_c = WEIGHT_W'(wc);
		s.red = COLOR_W'(r);
		s.green = COLOR_W'(g);
		s.blue = COLOR_W'(b);
		sample_backlog.push_back(s);
	endtask

	task automatic add_random_samples(int n);
		int kind, idx, tc, w0, w1, w2;
		tc = (reg_tri_count > MAX_TRIANGLES) ? MAX_TRIANGLES : reg_tri_count;
		for (int i = 0; i < n; i++) begin
			kind = $urandom_range(99);
			if (kind < 85 && tc > 0)
				idx = $urandom_range(tc - 1);
			else
				idx = $urandom_range(4095);
			if (kind < 90) begin
				w0 = $urandom_range(32768);
				w1 = $urandom_range(32768 - w0);
				w2 = 32768 - w0 - w1;
				case ($urandom_range(2))
					0: add_sample(idx, w0, w1, w2, $urandom_range(255), $urandom_range(255),
						$urandom_range(255));
					1: add_sample(idx, w2, w0, w1, $urandom_range(255), $urandom_range(255),
						$urandom_range(255));
					default: add_sample(idx, w1, w2, w0, $urandom_range(255),
						$urandom_range(255), $urandom_range(255));
				endcase
			end else begin
				add_sample(idx, $urandom_range(65535), $urandom_range(65535),
					$urandom_range(65535), $urandom_range(255), $urandom_range(255),
					$urandom_range(255));
			end
		end
	endtask

	task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			REG_TEXTURE_WIDTH:   reg_tex_w = data[DIM_W-1:0];
			REG_TEXTURE_HEIGHT:  reg_tex_h = data[DIM_W-1:0];
			REG_TRIANGLE_COUNT:  reg_tri_count = data[COUNT_W-1:0];
			REG_SQUARES_PER_ROW: reg_sq_per_row = data[SPR_W-1:0];
			REG_CELL_WIDTH:      reg_cell_w = data[CELL_W-1:0];
			REG_CELL_HEIGHT:     reg_cell_h = data[CELL_W-1:0];
			default: ;
		endcase
	endtask

	task automatic wait_drained();
		while (sample_backlog.size() != 0 || sample_valid || expected_writes.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	initial begin : stimulus
		cfg_plan[1] = '{1024, 1024, 4096, 64, 16, 16};
		cfg_plan[2] = '{1, 1, 0, 1, 4, 4};
		cfg_plan[3] = '{2047, 2047, 8191, 127, 2047, 2047};
		cfg_plan[4] = '{0, 5, 100, 0, 3, 0};
		cfg_plan[5] = '{64, 48, 200, 4, 0, 1};
		cfg_plan[6] = '{640, 480, 512, 10, 64, 60};
		cfg_plan[7] = '{1000, 700, 4096, 7, 143, 100};
		for (int ph = 8; ph < PHASES; ph++)
			cfg_plan[ph] = '{CFG_DATA_W'($urandom_range(1, 1024)),
				CFG_DATA_W'($urandom_range(1, 1024)), CFG_DATA_W'($urandom_range(4096)),
				CFG_DATA_W'($urandom_range(1, 64)), CFG_DATA_W'($urandom_range(4, 256)),
				CFG_DATA_W'($urandom_range(4, 256))};

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int ph = 0; ph < PHASES; ph++) begin
			send_gap_pct = (ph < 4) ? 27 : (ph < 8) ? 73 : 0;
			recv_hold_pct = (ph < 4) ? 73 : (ph < 8) ? 27 : 0;
			if (ph == 0) begin
				// reset configuration: vertices, index bounds, weight extremes
				add_sample(0, 32768, 0, 0, 255, 0, 0);
				add_sample(1, 0, 32768, 0, 0, 255, 0);
				add_sample(2, 0, 0, 32768, 0, 0, 255);
				add_sample(11, 10923, 10923, 10922, 255, 255, 255);
				add_sample(12, 32768, 0, 0, 1, 2, 3);
				add_sample(4095, 65535, 65535, 65535, 255, 255, 255);
				add_sample(5, 0, 0, 0, 0, 0, 0);
				add_sample(10, 65535, 65535, 65535, 170, 85, 170);
				add_sample(7, 32768, 32768, 0, 85, 170, 85);
				add_sample(3, 16384, 16384, 0, 15, 240, 15);
				add_sample(9, 0, 16384, 16384, 240, 15, 240);
				add_sample(6, 65535, 0, 0, 128, 64, 32);
				add_sample(8, 1, 2, 4, 127, 254, 1);
				add_sample(4, 0, 32768, 0, 33, 66, 99);
				add_sample(11, 0, 0, 32768, 200, 100, 50);
				add_sample(10, 32767, 1, 0, 7, 8, 9);
				add_sample(2730, 21845, 43690, 0, 0, 0, 0);
			end else begin
				wait_drained();
				write_reg(REG_TEXTURE_WIDTH, cfg_plan[ph][0]);
				write_reg(REG_TEXTURE_HEIGHT, cfg_plan[ph][1]);
				write_reg(REG_TRIANGLE_COUNT, cfg_plan[ph][2]);
				write_reg(REG_SQUARES_PER_ROW, cfg_plan[ph][3]);
				write_reg(REG_CELL_WIDTH, cfg_plan[ph][4]);
				write_reg(REG_CELL_HEIGHT, cfg_plan[ph][5]);
				// tiny and zero cells: vertices land left of and above the origin
				if (ph == 4 || ph == 5) begin
					add_sample(0, 0, 32768, 0, 1, 1, 1);
					add_sample(1, 0, 0, 32768, 2, 2, 2);
					add_sample(0, 0, 16384, 16384, 3, 3, 3);
				end
			end
			add_random_samples(ITEMS_PER_PH);
			if (ph == 9)
				hold_armed = 1'b1;
		end

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("[atlas_triangle_texel_writer_unit] OK");
		else
			$display("[atlas_triangle_texel_writer_unit] ERROR");
		$finish;
	end

endmodule
